@@ rtl/core/reversible_ring_stack_unit_defines.svh @@
// Assertion macros for the checker file of the ring stack unit.
// No dependencies; include by bare file name.
`ifndef REVERSIBLE_RING_STACK_UNIT_DEFINES_SVH
`define REVERSIBLE_RING_STACK_UNIT_DEFINES_SVH

// Check a property while reset is released.
`define RRS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define RRS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/rrs_pkg.sv @@
// Shared types, constants and width helpers for the ring stack unit.
// No dependencies.
package rrs_pkg;

    localparam int DEPTH      = 16;
    localparam int ELEM_WIDTH = 32;
    localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int WORD_W     = 32;
    localparam int DU_W       = 5;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_FLIP = 2'd2,
        OP_PEEK = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_PUSH_FULL = 2'd2
    } t_status;

    // Result bookkeeping that travels beside the memory read.
    typedef struct packed {
        t_status                 status;
        logic [CNT_W-1:0]        count;
        logic                    fwd;
        logic [ELEM_WIDTH-1:0]   fwd_val;
    } t_meta;

    function automatic logic [ELEM_WIDTH-1:0] to_elem(logic [WORD_W-1:0] v);
        logic [63:0] t;
        t = 64'(v);
        return t[ELEM_WIDTH-1:0];
    endfunction

    function automatic logic [WORD_W-1:0] to_word(logic [ELEM_WIDTH-1:0] e);
        logic [63:0] t;
        t = 64'(e);
        return t[WORD_W-1:0];
    endfunction

    function automatic logic [DU_W-1:0] to_depth_used(logic [CNT_W-1:0] c);
        logic [63:0] t;
        t = 64'(c);
        return t[DU_W-1:0];
    endfunction

endpackage

@@ rtl/core/rrs_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module rrs_ram #(
    parameter int W = 32,
    parameter int D = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_waddr,
    input  logic [W-1:0]                         i_wdata,
    input  logic                                 i_re,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_raddr,
    output logic [W-1:0]                         o_rdata
);

    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

@@ rtl/core/rrs_ctrl.sv @@
// Pointer, direction and count state of the ring stack; drives the store ports.
// Depends on rrs_pkg.
module rrs_ctrl import rrs_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req,
    input  t_op                   i_op,
    input  logic [WORD_W-1:0]     i_value,
    output logic                  o_we,
    output logic [PTR_W-1:0]      o_waddr,
    output logic [ELEM_WIDTH-1:0] o_wdata,
    output logic                  o_re,
    output logic [PTR_W-1:0]      o_raddr,
    output t_meta                 o_meta
);

    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [PTR_W-1:0] r_bot, n_bot;
    logic [PTR_W-1:0] r_top, n_top;
    logic             r_grow, n_grow;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [PTR_W-1:0] ptr_inc, ptr_dec;
    t_status          status;
    logic             push_ok;

    assign ptr_inc = (r_top == LAST_PTR) ? '0 : r_top + 1'b1;
    assign ptr_dec = (r_top == '0) ? LAST_PTR : r_top - 1'b1;

    always_comb begin
        n_bot   = r_bot;
        n_top   = r_top;
        n_grow  = r_grow;
        n_cnt   = r_cnt;
        status  = ST_OK;
        push_ok = 1'b0;
        case (i_op)
            OP_PUSH: begin
                if (r_cnt == FULL_CNT) begin
                    status = ST_PUSH_FULL;
                end else begin
                    push_ok = 1'b1;
                    n_cnt   = r_cnt + 1'b1;
                    if (r_cnt == '0) begin
                        // restart the ring from entry zero
                        n_grow = 1'b1;
                        n_bot  = '0;
                        n_top  = '0;
                    end else begin
                        n_top = r_grow ? ptr_inc : ptr_dec;
                    end
                end
            end
            OP_POP: begin
                if (r_cnt == '0) begin
                    status = ST_POP_EMPTY;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                    n_top = r_grow ? ptr_dec : ptr_inc;
                end
            end
            OP_FLIP: begin
                n_grow = ~r_grow;
                n_top  = r_bot;
                n_bot  = r_top;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bot  <= '0;
            r_top  <= '0;
            r_grow <= 1'b1;
            r_cnt  <= '0;
        end else if (i_req) begin
            r_bot  <= n_bot;
            r_top  <= n_top;
            r_grow <= n_grow;
            r_cnt  <= n_cnt;
        end
    end

    assign o_we    = i_req & push_ok;
    assign o_waddr = n_top;
    assign o_wdata = to_elem(i_value);
    // an accepted push answers with its own value, so skip the read then
    assign o_re    = i_req & ~push_ok;
    assign o_raddr = n_top;

    assign o_meta.status  = status;
    assign o_meta.count   = n_cnt;
    assign o_meta.fwd     = push_ok;
    assign o_meta.fwd_val = to_elem(i_value);

endmodule

@@ rtl/core/reversible_ring_stack_unit.sv @@
// Reversible ring stack: LIFO in a ring store with a direction bit; flip reverses it.
// Input request: s_axis_tuser = operation (0 push, 1 pop, 2 flip, 3 peek),
//   s_axis_tdata = push value (ignored unless push).
// Output: one result per request on m_axis: top value, count and status in
//   tdata, top-valid flag in tuser. Push on a full stack reports status 2 and
//   changes nothing; pop on an empty stack reports status 1.
// Pipeline: pointer update and store access in the first stage, registered read
//   data and the result register in the second.
// Throughput: one request per cycle unless the output stalls; the store's single
//   read port and its registered read data are covered by a two-deep result
//   pipeline.
// Reset: synchronous, active low; empties the stack, growth direction to
//   higher entries; the store itself is not cleared and needs no sweep.
// Stall: while m_axis_tready is low the result holds; one more request is
//   taken into the read stage, then s_axis_tready drops until the output moves.
// Depends on rrs_pkg, rrs_ctrl and rrs_ram.
module reversible_ring_stack_unit import rrs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] push_value
    input  logic [1:0]  s_axis_tuser,   // [1:0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] top_value, [36:32] depth_used,
                                        // [38:37] status, [39] zero
    output logic        m_axis_tuser    // [0] top_valid
);

    logic                  req;
    logic                  we, re;
    logic [PTR_W-1:0]      waddr, raddr;
    logic [ELEM_WIDTH-1:0] wdata, rdata;
    t_meta                 meta;

    logic                  r_s1_valid;
    t_meta                 r_s1_meta;
    logic                  out_free, s1_move;
    logic                  r_out_valid;
    logic [WORD_W-1:0]     r_out_value, n_out_value;
    logic [DU_W-1:0]       r_out_depth;
    t_status               r_out_status;
    logic                  r_out_tv;
    logic [ELEM_WIDTH-1:0] s1_elem;

    assign out_free      = ~r_out_valid | m_axis_tready;
    assign s1_move       = r_s1_valid & out_free;
    assign s_axis_tready = ~r_s1_valid | out_free;
    assign req           = s_axis_tvalid & s_axis_tready;

    rrs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .i_op    (t_op'(s_axis_tuser)),
        .i_value (s_axis_tdata),
        .o_we    (we),
        .o_waddr (waddr),
        .o_wdata (wdata),
        .o_re    (re),
        .o_raddr (raddr),
        .o_meta  (meta)
    );

    rrs_ram #(
        .W (ELEM_WIDTH),
        .D (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // read data holds while the stage stalls, since reads fire only on accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req) begin
            r_s1_meta <= meta;
        end
    end

    assign s1_elem = r_s1_meta.fwd ? r_s1_meta.fwd_val : rdata;

    always_comb begin
        n_out_value = '0;
        if (r_s1_meta.count != '0) begin
            n_out_value = to_word(s1_elem);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_value  <= n_out_value;
            r_out_depth  <= to_depth_used(r_s1_meta.count);
            r_out_status <= r_s1_meta.status;
            r_out_tv     <= (r_s1_meta.count != '0);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_status, r_out_depth, r_out_value};
    assign m_axis_tuser  = r_out_tv;

endmodule

@@ rtl/core/rrs_checker.sv @@
// Port-level checks for the ring stack unit, bound to the top level.
// Depends on rrs_pkg and reversible_ring_stack_unit_defines.svh.
`include "reversible_ring_stack_unit_defines.svh"

module rrs_checker import rrs_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    `RRS_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")
    `RRS_ASSERT(a_valid_flag, i_clk, i_rst_n, m_axis_tvalid |-> (m_axis_tuser == (m_axis_tdata[36:32] != 5'd0)), "top_valid disagrees with depth_used")
    `RRS_ASSERT(a_pop_empty, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tdata[38:37] == ST_POP_EMPTY) |-> (m_axis_tdata[36:32] == 5'd0) && (m_axis_tdata[31:0] == 32'd0), "pop on empty reported a non-empty stack")
    `RRS_ASSERT(a_push_full, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tdata[38:37] == ST_PUSH_FULL) |-> (m_axis_tdata[36:32] == to_depth_used(CNT_W'(DEPTH))), "push rejected below capacity")
    `RRS_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !m_axis_tvalid, "result valid right after reset")

endmodule

bind reversible_ring_stack_unit rrs_checker u_rrs_checker (.*);

@@ verif/tb_reversible_ring_stack_unit.sv @@
`timescale 1ns / 100ps
// Testbench for reversible_ring_stack_unit: directed and random push, pop, flip and
// peek requests, checked against a shadow stack kept inside the bench.
// Depends on rrs_pkg and the unit's RTL.
module tb_reversible_ring_stack_unit;
    import rrs_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 10;
    localparam int IDLE_PCT     = 37;
    localparam int SETTLE       = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 1500;
    localparam int BURST_ITEMS  = 400;

    typedef struct packed {
        logic [WORD_W-1:0] top_value;
        logic              top_valid;
        logic [DU_W-1:0]   depth_used;
        t_status           status;
    } t_stack_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [31:0] push_value
    logic [1:0]  s_axis_tuser;   // [1:0] operation
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // [31:0] top_value, [36:32] depth_used, [38:37] status, [39] zero
    logic        m_axis_tuser;   // [0] top_valid

    // Shadow copy of the stack state.
    logic [WORD_W-1:0] shadow_ring [DEPTH];
    logic [PTR_W-1:0]  shadow_bottom;
    logic [PTR_W-1:0]  shadow_top;
    logic              shadow_grow_right;
    logic [CNT_W-1:0]  shadow_count;

    t_stack_result pending_results [$];
    t_stack_result want_result;
    logic          no_idle = 1'b0;
    int            error_count  = 0;
    int            result_index = 0;
    int            cycle_count  = 0;

    reversible_ring_stack_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ERROR: timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Stall the result side at random unless a no-idle stretch is running.
    always @(posedge i_clk) begin
        m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    end

    function automatic logic [PTR_W-1:0] ring_neighbor(logic [PTR_W-1:0] p, logic up);
        if (up)
            return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
        return (p == '0) ? PTR_W'(DEPTH - 1) : p - 1'b1;
    endfunction

    task automatic predict_stack_op(input t_op op, input logic [WORD_W-1:0] value);
        t_stack_result    r;
        logic [PTR_W-1:0] swap;
        r.status = ST_OK;
        case (op)
            OP_PUSH: begin
                if (shadow_count == CNT_W'(DEPTH)) begin
                    r.status = ST_PUSH_FULL;
                end else begin
                    // an empty stack always restarts at entry 0, growing up
                    if (shadow_count == '0) begin
                        shadow_grow_right = 1'b1;
                        shadow_bottom     = '0;
                        shadow_top        = '0;
                    end else begin
                        shadow_top = ring_neighbor(shadow_top, shadow_grow_right);
                    end
                    shadow_ring[shadow_top] = value;
                    shadow_count = shadow_count + 1'b1;
                end
            end
            OP_POP: begin
                if (shadow_count == '0) begin
                    r.status = ST_POP_EMPTY;
                end else begin
                    shadow_top   = ring_neighbor(shadow_top, !shadow_grow_right);
                    shadow_count = shadow_count - 1'b1;
                end
            end
            OP_FLIP: begin
                swap              = shadow_top;
                shadow_top        = shadow_bottom;
                shadow_bottom     = swap;
                shadow_grow_right = !shadow_grow_right;
            end
            default: ;
        endcase
        r.top_valid  = (shadow_count != '0);
        r.top_value  = r.top_valid ? shadow_ring[shadow_top] : '0;
        r.depth_used = DU_W'(shadow_count);
        pending_results.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [39:0] got,
                                   input logic [39:0] want);
        $display("ERROR: result %0d %s: got %0h, expected %0h", result_index, what, got, want);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("with no request pending", m_axis_tdata, '0);
            end else begin
                want_result = pending_results.pop_front();
                if (m_axis_tdata[31:0] !== want_result.top_value)
                    report_mismatch("top_value", 40'(m_axis_tdata[31:0]),
                                    40'(want_result.top_value));
                if (m_axis_tuser !== want_result.top_valid)
                    report_mismatch("top_valid", 40'(m_axis_tuser),
                                    40'(want_result.top_valid));
                if (m_axis_tdata[36:32] !== want_result.depth_used)
                    report_mismatch("depth_used", 40'(m_axis_tdata[36:32]),
                                    40'(want_result.depth_used));
                if (m_axis_tdata[38:37] !== want_result.status)
                    report_mismatch("status", 40'(m_axis_tdata[38:37]),
                                    40'(want_result.status));
                if (m_axis_tdata[39] !== 1'b0)
                    report_mismatch("pad bit", 40'(m_axis_tdata[39]), 40'(1'b0));
            end
            result_index++;
        end
    end

    // Hold the request until accepted, then record its expected result.
    task automatic send_request(input t_op op, input logic [WORD_W-1:0] value);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= value;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        predict_stack_op(op, value);
    endtask

    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [WORD_W-1:0] pick_value();
        case ($urandom_range(15))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_empty_stack();
        send_request(OP_PEEK, 32'h1234_5678);
        send_request(OP_POP,  32'hffff_ffff);
        send_request(OP_FLIP, 32'h0000_0000);
        send_request(OP_PEEK, 32'hffff_ffff);
    endtask

    task automatic test_value_extremes();
        send_request(OP_PUSH, 32'h7fff_ffff);
        send_request(OP_PUSH, 32'h8000_0000);
        send_request(OP_PUSH, 32'h0000_0000);
        send_request(OP_PUSH, 32'hffff_ffff);
        send_request(OP_FLIP, 32'h0);
        send_request(OP_PEEK, 32'h0);
        send_request(OP_POP,  32'h0);
        send_request(OP_FLIP, 32'h0);
        send_request(OP_POP,  32'h0);
        send_request(OP_POP,  32'h0);
        send_request(OP_FLIP, 32'h0);
        send_request(OP_POP,  32'h0);
        // reversed direction left behind on empty; push must restart growing up
        send_request(OP_PUSH, 32'h5555_aaaa);
        send_request(OP_PUSH, 32'haaaa_5555);
        send_request(OP_PEEK, 32'h0);
    endtask

    task automatic test_full_stack();
        while (shadow_count != CNT_W'(DEPTH))
            send_request(OP_PUSH, pick_value());
        send_request(OP_PUSH, 32'hdead_beef);
        send_request(OP_FLIP, 32'h0);
        send_request(OP_PUSH, 32'h0bad_f00d);
        send_request(OP_POP,  32'h0);
        send_request(OP_PUSH, 32'hcafe_0001);
    endtask

    // Random phases lean toward filling or draining so both ends get hit often.
    task automatic run_random_phases(input int items);
        int sent;
        int phase_len;
        int push_pct;
        int pick;
        sent = 0;
        while (sent < items) begin
            phase_len = $urandom_range(80, 20);
            case ($urandom_range(2))
                0:       push_pct = 65;
                1:       push_pct = 20;
                default: push_pct = 40;
            endcase
            repeat (phase_len) begin
                pick = $urandom_range(99);
                if (pick < push_pct)
                    send_request(OP_PUSH, pick_value());
                else if (pick < 78)
                    send_request(OP_POP, pick_value());
                else if (pick < 90)
                    send_request(OP_FLIP, pick_value());
                else
                    send_request(OP_PEEK, pick_value());
                sent++;
            end
        end
    endtask

    task automatic test_random_mix();
        run_random_phases(RANDOM_ITEMS / 2);
        // pause the sender until the pipeline is empty
        wait_results_drained();
        run_random_phases(RANDOM_ITEMS / 2);
    endtask

    task automatic test_no_idle_burst();
        no_idle = 1'b1;
        run_random_phases(BURST_ITEMS);
        no_idle = 1'b0;
    endtask

    initial begin
        for (int i = 0; i < DEPTH; i++)
            shadow_ring[i] = '0;
        shadow_bottom     = '0;
        shadow_top        = '0;
        shadow_grow_right = 1'b1;
        shadow_count      = '0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_PUSH;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_stack();
        test_value_extremes();
        test_full_stack();
        test_random_mix();
        test_no_idle_burst();

        wait_results_drained();
        repeat (SETTLE) @(posedge i_clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ reversible_ring_stack_unit.f @@
+incdir+rtl/core
rtl/core/rrs_pkg.sv
rtl/core/rrs_ram.sv
rtl/core/rrs_ctrl.sv
rtl/core/reversible_ring_stack_unit.sv
rtl/core/rrs_checker.sv
verif/tb_reversible_ring_stack_unit.sv
